@@ design/fcl_pkg.sv @@
// Package: widths, status codes and sideband types of the 2D friction contact solver.
`default_nettype none
package fcl_pkg;
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int MU_BITS   = WORD_BITS - 1;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int QUOT_BITS = WORD_BITS;

	localparam logic [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SINGULAR = 2'd1,
		ST_DIV_ZERO = 2'd2
	} fcl_status_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] qn;
		logic [MU_BITS-1:0]          mu;
		logic signed [WORD_BITS-1:0] wnn;
		logic signed [PROD_BITS-1:0] mu_wnt;
		logic                        skip;
		logic                        sing;
		logic                        neg_n;
		logic                        over_n;
	} fcl_sidea_t;

	typedef struct packed {
		logic                        neg_t;
		logic                        over_t;
	} fcl_sidet_t;

	typedef struct packed {
		logic                        skip;
		logic                        sing;
		logic                        cone;
		logic                        low;
		logic                        divzero;
		logic                        neg2;
		logic                        over2;
		logic                        qn_neg;
		logic [MU_BITS-1:0]          mu;
		logic signed [WORD_BITS-1:0] pn;
		logic signed [WORD_BITS-1:0] pt;
	} fcl_sideb_t;
endpackage
`default_nettype wire

@@ design/fcl_contact_if.sv @@
// Interface: contact word channel (block entries, free velocity, friction coefficient).
`default_nettype none
interface fcl_contact_if;
	logic                                valid;
	logic                                ready;
	logic signed [fcl_pkg::WORD_BITS-1:0] w_nn;
	logic signed [fcl_pkg::WORD_BITS-1:0] w_tn;
	logic signed [fcl_pkg::WORD_BITS-1:0] w_nt;
	logic signed [fcl_pkg::WORD_BITS-1:0] w_tt;
	logic signed [fcl_pkg::WORD_BITS-1:0] q_normal;
	logic signed [fcl_pkg::WORD_BITS-1:0] q_tangent;
	logic [fcl_pkg::MU_BITS-1:0]          friction_coeff;

	modport source (output valid, w_nn, w_tn, w_nt, w_tt, q_normal, q_tangent,
		friction_coeff, input ready);
	modport sink (input valid, w_nn, w_tn, w_nt, w_tt, q_normal, q_tangent,
		friction_coeff, output ready);
endinterface
`default_nettype wire

@@ design/fcl_result_if.sv @@
// Interface: impulse word channel (normal and tangential impulse, status).
`default_nettype none
interface fcl_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [fcl_pkg::WORD_BITS-1:0] impulse_normal;
	logic signed [fcl_pkg::WORD_BITS-1:0] impulse_tangent;
	logic [1:0]                           status;

	modport source (output valid, impulse_normal, impulse_tangent, status, input ready);
	modport sink (input valid, impulse_normal, impulse_tangent, status, output ready);
endinterface
`default_nettype wire

@@ design/fcl_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, sideband travels along.
`default_nettype none
module fcl_div #(
	parameter int DW = 64,
	parameter int QB = 32,
	parameter int SB = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [DW-1:0] in_rem,
	input  wire logic [DW-1:0] in_den,
	input  wire logic [QB-1:0] in_low,
	input  wire logic [SB-1:0] in_side,
	output logic               out_valid,
	output logic [QB-1:0]      out_q,
	output logic [SB-1:0]      out_side
);
	logic [DW-1:0] rem_s  [QB];
	logic [DW-1:0] den_s  [QB];
	logic [QB-1:0] low_s  [QB];
	logic [QB-1:0] q_s    [QB];
	logic [SB-1:0] side_s [QB];
	logic          v_s    [QB];

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DW-1:0] src_rem;
		logic [DW-1:0] src_den;
		logic [QB-1:0] src_low;
		logic [QB-1:0] src_q;
		logic [SB-1:0] src_side;
		logic          src_v;
		logic [DW:0]   rem2;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign src_rem  = in_rem;
			assign src_den  = in_den;
			assign src_low  = in_low;
			assign src_q    = '0;
			assign src_side = in_side;
			assign src_v    = in_valid;
		end else begin : g_next
			assign src_rem  = rem_s[k-1];
			assign src_den  = den_s[k-1];
			assign src_low  = low_s[k-1];
			assign src_q    = q_s[k-1];
			assign src_side = side_s[k-1];
			assign src_v    = v_s[k-1];
		end

		always_comb begin
			rem2 = {src_rem, src_low[QB-1]};
			diff = rem2 - {1'b0, src_den};
			ge   = rem2 >= {1'b0, src_den};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DW-1:0] : rem2[DW-1:0];
				den_s[k]  <= src_den;
				low_s[k]  <= {src_low[QB-2:0], 1'b0};
				q_s[k]    <= {src_q[QB-2:0], ge};
				side_s[k] <= src_side;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= src_v;
			end
		end
	end

	assign out_valid = v_s[QB-1];
	assign out_q     = q_s[QB-1];
	assign out_side  = side_s[QB-1];
endmodule
`default_nettype wire

@@ design/friction_contact_2d_local_solve_top.sv @@
// Top level: pipelined 2D Coulomb friction contact local solver.
// Throughput: one contact word per cycle while the output is not stalled; five setup stages,
// a 32-stage divider for the Cramer quotients, six cone stages, a 32-stage divider for the
// edge quotient, three end stages.
// The whole pipeline holds while the output word waits.
// Reset clears all valid bits and sets min_determinant to 1.
`default_nettype none
module friction_contact_2d_local_solve_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         min_det_we,
	input  wire logic [fcl_pkg::MU_BITS-1:0]  min_det_wdata,
	fcl_contact_if.sink                       contact,
	fcl_result_if.source                      result
);
	import fcl_pkg::*;

	localparam int W = WORD_BITS;
	localparam int P = PROD_BITS;
	localparam int F = FRAC_BITS;

	function automatic logic signed [P-1:0] smul(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic [P-1:0] ax;
		logic [P-1:0] bx;
		ax = {{W{a[W-1]}}, a};
		bx = {{W{b[W-1]}}, b};
		return ax * bx;
	endfunction

	function automatic logic signed [W-1:0] qfin(input logic [W-1:0] q, input logic over,
			input logic neg);
		logic [W-1:0] lim;
		logic [W-1:0] m;
		lim = neg ? SMIN : SMAX;
		m   = (over || q > lim) ? lim : q;
		return neg ? -m : m;
	endfunction

	logic en;
	logic [MU_BITS-1:0] min_det_q;

	assign en            = !result.valid || result.ready;
	assign contact.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_det_q <= MU_BITS'(1);
		end else if (min_det_we) begin
			min_det_q <= min_det_wdata;
		end
	end

	// stage 1: input word
	logic v_s1;
	logic signed [W-1:0] wnn_s1, wtn_s1, wnt_s1, wtt_s1, qn_s1, qt_s1;
	logic [MU_BITS-1:0] mu_s1;
	// stage 2: products
	logic v_s2;
	logic signed [P-1:0] pda_s2, pdb_s2, pna_s2, pnb_s2, pta_s2, ptb_s2, muwnt_s2;
	logic signed [W-1:0] qn_s2, wnn_s2;
	logic [MU_BITS-1:0] mu_s2;
	// stage 3: determinant and numerators
	logic v_s3;
	logic signed [P:0] det_s3, numn_s3, numt_s3;
	logic signed [P-1:0] muwnt_s3;
	logic signed [W-1:0] qn_s3, wnn_s3;
	logic [MU_BITS-1:0] mu_s3;
	// stage 4: magnitudes and singular check
	logic v_s4;
	logic [P-1:0] den_s4, magn_s4, magt_s4;
	logic negn_s4, negt_s4, sing_s4;
	logic signed [P-1:0] muwnt_s4;
	logic signed [W-1:0] qn_s4, wnn_s4;
	logic [MU_BITS-1:0] mu_s4;
	// stage 5: overflow checks
	logic v_s5;
	logic [P-1:0] den_s5, magn_s5, magt_s5;
	fcl_sidea_t sa_s5;
	fcl_sidet_t st_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= contact.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wnn_s1 <= contact.w_nn;
			wtn_s1 <= contact.w_tn;
			wnt_s1 <= contact.w_nt;
			wtt_s1 <= contact.w_tt;
			qn_s1  <= contact.q_normal;
			qt_s1  <= contact.q_tangent;
			mu_s1  <= contact.friction_coeff;

			pda_s2   <= smul(wnn_s1, wtt_s1);
			pdb_s2   <= smul(wnt_s1, wtn_s1);
			pna_s2   <= smul(wnt_s1, qt_s1);
			pnb_s2   <= smul(wtt_s1, qn_s1);
			pta_s2   <= smul(wtn_s1, qn_s1);
			ptb_s2   <= smul(wnn_s1, qt_s1);
			muwnt_s2 <= smul({1'b0, mu_s1}, wnt_s1);
			qn_s2    <= qn_s1;
			wnn_s2   <= wnn_s1;
			mu_s2    <= mu_s1;

			det_s3   <= {pda_s2[P-1], pda_s2} - {pdb_s2[P-1], pdb_s2};
			numn_s3  <= {pna_s2[P-1], pna_s2} - {pnb_s2[P-1], pnb_s2};
			numt_s3  <= {pta_s2[P-1], pta_s2} - {ptb_s2[P-1], ptb_s2};
			muwnt_s3 <= muwnt_s2;
			qn_s3    <= qn_s2;
			wnn_s3   <= wnn_s2;
			mu_s3    <= mu_s2;

			den_s4   <= det_s3[P-1:0];
			magn_s4  <= numn_s3[P] ? P'(-numn_s3) : numn_s3[P-1:0];
			magt_s4  <= numt_s3[P] ? P'(-numt_s3) : numt_s3[P-1:0];
			negn_s4  <= numn_s3[P];
			negt_s4  <= numt_s3[P];
			sing_s4  <= det_s3[P] || (det_s3 == '0) ||
				(det_s3[P-1:0] < {{(P-MU_BITS-F){1'b0}}, min_det_q, {F{1'b0}}});
			muwnt_s4 <= muwnt_s3;
			qn_s4    <= qn_s3;
			wnn_s4   <= wnn_s3;
			mu_s4    <= mu_s3;

			den_s5        <= den_s4;
			magn_s5       <= magn_s4;
			magt_s5       <= magt_s4;
			sa_s5.qn      <= qn_s4;
			sa_s5.mu      <= mu_s4;
			sa_s5.wnn     <= wnn_s4;
			sa_s5.mu_wnt  <= muwnt_s4;
			sa_s5.skip    <= !qn_s4[W-1] && (qn_s4 != '0);
			sa_s5.sing    <= sing_s4;
			sa_s5.neg_n   <= negn_s4;
			sa_s5.over_n  <= {{F{1'b0}}, magn_s4[P-1:F]} >= den_s4;
			st_s5.neg_t   <= negt_s4;
			st_s5.over_t  <= {{F{1'b0}}, magt_s4[P-1:F]} >= den_s4;
		end
	end

	// Cramer quotients
	logic da_v, dt_v;
	logic [QUOT_BITS-1:0] da_q, dt_q;
	logic [$bits(fcl_sidea_t)-1:0] da_side;
	logic [$bits(fcl_sidet_t)-1:0] dt_side;

	fcl_div #(.DW(P), .QB(QUOT_BITS), .SB($bits(fcl_sidea_t))) u_div_n (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5),
		.in_rem({{F{1'b0}}, magn_s5[P-1:F]}), .in_den(den_s5),
		.in_low({magn_s5[F-1:0], {(QUOT_BITS-F){1'b0}}}), .in_side(sa_s5),
		.out_valid(da_v), .out_q(da_q), .out_side(da_side)
	);

	fcl_div #(.DW(P), .QB(QUOT_BITS), .SB($bits(fcl_sidet_t))) u_div_t (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s5),
		.in_rem({{F{1'b0}}, magt_s5[P-1:F]}), .in_den(den_s5),
		.in_low({magt_s5[F-1:0], {(QUOT_BITS-F){1'b0}}}), .in_side(st_s5),
		.out_valid(dt_v), .out_q(dt_q), .out_side(dt_side)
	);

	fcl_sidea_t sa_d;
	fcl_sidet_t st_d;
	assign sa_d = fcl_sidea_t'(da_side);
	assign st_d = fcl_sidet_t'(dt_side);

	// cone stages
	logic v_e1, v_e2, v_e3, v_e4, v_e5, v_e6;
	fcl_sidea_t sa_e1, sa_e2, sa_e3, sa_e4;
	logic signed [W-1:0] pn_e1, pt_e1, pn_e2, pt_e2, pn_e3, pt_e3, pn_e4, pt_e4;
	logic signed [W-1:0] pn_e5, pt_e5;
	logic signed [P-1:0] mupn_e2;
	logic cone_e3, low_e3, cone_e4, low_e4, cone_e5, low_e5;
	logic signed [P-1:0] div_e4;
	logic [P-1:0] dmag_e5, dmag_e6;
	logic [W-1:0] qmag_e5, qmag_e6;
	logic skip_e5, sing_e5, dz_e5, neg2_e5, qneg_e5;
	logic [MU_BITS-1:0] mu_e5;
	fcl_sideb_t sb_e6;
	logic [W-1:0] ptmag_e2;

	assign ptmag_e2 = pt_e2[W-1] ? -pt_e2 : pt_e2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_e1 <= 1'b0;
			v_e2 <= 1'b0;
			v_e3 <= 1'b0;
			v_e4 <= 1'b0;
			v_e5 <= 1'b0;
			v_e6 <= 1'b0;
		end else if (en) begin
			v_e1 <= da_v && dt_v;
			v_e2 <= v_e1;
			v_e3 <= v_e2;
			v_e4 <= v_e3;
			v_e5 <= v_e4;
			v_e6 <= v_e5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sa_e1 <= sa_d;
			pn_e1 <= qfin(da_q, sa_d.over_n, sa_d.neg_n);
			pt_e1 <= qfin(dt_q, st_d.over_t, st_d.neg_t);

			sa_e2   <= sa_e1;
			pn_e2   <= pn_e1;
			pt_e2   <= pt_e1;
			mupn_e2 <= smul({1'b0, sa_e1.mu}, pn_e1);

			sa_e3   <= sa_e2;
			pn_e3   <= pn_e2;
			pt_e3   <= pt_e2;
			cone_e3 <= $signed({{(P-W-F){1'b0}}, ptmag_e2, {F{1'b0}}}) > mupn_e2;
			low_e3  <= ($signed({{(P-W-F){pt_e2[W-1]}}, pt_e2, {F{1'b0}}}) + mupn_e2) < 0;

			sa_e4   <= sa_e3;
			pn_e4   <= pn_e3;
			pt_e4   <= pt_e3;
			cone_e4 <= cone_e3;
			low_e4  <= low_e3;
			div_e4  <= low_e3 ?
				$signed({{(P-W-F){sa_e3.wnn[W-1]}}, sa_e3.wnn, {F{1'b0}}}) - sa_e3.mu_wnt :
				$signed({{(P-W-F){sa_e3.wnn[W-1]}}, sa_e3.wnn, {F{1'b0}}}) + sa_e3.mu_wnt;

			pn_e5   <= pn_e4;
			pt_e5   <= pt_e4;
			cone_e5 <= cone_e4;
			low_e5  <= low_e4;
			dmag_e5 <= div_e4[P-1] ? -div_e4 : div_e4;
			dz_e5   <= div_e4 == '0;
			neg2_e5 <= div_e4[P-1];
			qmag_e5 <= -sa_e4.qn;
			qneg_e5 <= sa_e4.qn[W-1];
			skip_e5 <= sa_e4.skip;
			sing_e5 <= sa_e4.sing;
			mu_e5   <= sa_e4.mu;

			dmag_e6       <= dmag_e5;
			qmag_e6       <= qmag_e5;
			sb_e6.skip    <= skip_e5;
			sb_e6.sing    <= sing_e5;
			sb_e6.cone    <= cone_e5;
			sb_e6.low     <= low_e5;
			sb_e6.divzero <= dz_e5;
			sb_e6.neg2    <= neg2_e5;
			sb_e6.over2   <= {{(P-W){1'b0}}, qmag_e5} >= dmag_e5;
			sb_e6.qn_neg  <= qneg_e5;
			sb_e6.mu      <= mu_e5;
			sb_e6.pn      <= pn_e5;
			sb_e6.pt      <= pt_e5;
		end
	end

	// edge quotient
	logic db_v;
	logic [QUOT_BITS-1:0] db_q;
	logic [$bits(fcl_sideb_t)-1:0] db_side;

	fcl_div #(.DW(P), .QB(QUOT_BITS), .SB($bits(fcl_sideb_t))) u_div_e (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_e6),
		.in_rem({{(P-W){1'b0}}, qmag_e6}), .in_den(dmag_e6),
		.in_low('0), .in_side(sb_e6),
		.out_valid(db_v), .out_q(db_q), .out_side(db_side)
	);

	fcl_sideb_t sb_d;
	assign sb_d = fcl_sideb_t'(db_side);

	// end stages
	logic v_f1, v_f2;
	fcl_sideb_t sb_f1, sb_f2;
	logic signed [W-1:0] pn_f1, pn_f2;
	logic signed [P-1:0] mupn_f2;
	logic [P-1:0] pmag_f2;
	logic [P-F-1:0] m_f2;
	logic signed [W-1:0] ptr_f2, pte_f2;
	logic [1:0] st_f2;
	logic v_out_q;
	logic signed [W-1:0] pn_q, pt_q;
	logic [1:0] status_q;

	always_comb begin
		pmag_f2 = mupn_f2[P-1] ? -mupn_f2 : mupn_f2;
		m_f2    = pmag_f2[P-1:F];
		if (mupn_f2[P-1]) begin
			ptr_f2 = (m_f2 > {{(P-F-W){1'b0}}, SMIN}) ? SMIN : -m_f2[W-1:0];
		end else begin
			ptr_f2 = (m_f2 > {{(P-F-W){1'b0}}, SMAX}) ? SMAX : m_f2[W-1:0];
		end
		if (sb_f2.low) begin
			pte_f2 = (ptr_f2 == SMIN) ? SMAX : -ptr_f2;
		end else begin
			pte_f2 = ptr_f2;
		end
		priority if (sb_f2.skip) begin
			st_f2 = ST_OK;
		end else if (sb_f2.sing) begin
			st_f2 = ST_SINGULAR;
		end else if (sb_f2.cone && sb_f2.divzero) begin
			st_f2 = ST_DIV_ZERO;
		end else begin
			st_f2 = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1    <= 1'b0;
			v_f2    <= 1'b0;
			v_out_q <= 1'b0;
		end else if (en) begin
			v_f1    <= db_v;
			v_f2    <= v_f1;
			v_out_q <= v_f2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_f1 <= sb_d;
			priority if (sb_d.skip || sb_d.sing) begin
				pn_f1 <= '0;
			end else if (!sb_d.cone) begin
				pn_f1 <= sb_d.pn;
			end else if (sb_d.divzero) begin
				pn_f1 <= sb_d.qn_neg ? SMAX : '0;
			end else begin
				pn_f1 <= qfin(db_q, sb_d.over2, sb_d.neg2);
			end

			sb_f2   <= sb_f1;
			pn_f2   <= pn_f1;
			mupn_f2 <= smul({1'b0, sb_f1.mu}, pn_f1);

			pn_q     <= pn_f2;
			status_q <= st_f2;
			priority if (sb_f2.skip || sb_f2.sing) begin
				pt_q <= '0;
			end else if (!sb_f2.cone) begin
				pt_q <= sb_f2.pt;
			end else begin
				pt_q <= pte_f2;
			end
		end
	end

	assign result.valid           = v_out_q;
	assign result.impulse_normal  = pn_q;
	assign result.impulse_tangent = pt_q;
	assign result.status          = status_q;
endmodule
`default_nettype wire
